// ===== hdl/sths_pkg.sv =====
// Shared types and constants for the half-step stepper sequencer.
package sths_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic        direction;
    logic [23:0] total_steps;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         coil_pins;
    logic               driver_enable;
    logic               range_trigger;
    logic signed [31:0] position;
    logic               running;
  } out_item_t;

  // Both brake pins: bit 3 for coil A, bit 1 for coil B.
  localparam logic [3:0] BRAKE_MASK = 4'b1010;

  // Half-step coil pattern, indexed by phase.
  localparam logic [3:0] COIL_PATTERN [8] = '{
    4'h5, 4'h9, 4'h1, 4'h2, 4'h0, 4'h8, 4'h4, 4'h6
  };

endpackage

// ===== hdl/stepper_half_step_sequencer.sv =====
// Half-step stepper sequencer: top level with tick, start and stop handling.
//
// One result per input item, one item per cycle while results are taken. The input
// is accepted outside reset whenever the result register is empty or being drained
// in the same cycle, so items stream back to back, each result valid in the cycle after its transfer in.
// A tick advances the interval counter; when it reaches step_interval the motor
// takes one half step (or, once the run is over, both brakes engage). A start item
// loads direction and step count and raises driver_enable if both the count and
// step_interval are nonzero; a stop item ends the run and drops driver_enable.
// range_trigger pulses on one tick out of every TRIGGER_PERIOD+1 ticks.
// Write step_interval only while no result is pending.
module stepper_half_step_sequencer
  import sths_pkg::*;
#(
  parameter int PHASE_COUNT    = 8,
  parameter int TRIGGER_PERIOD = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] PHASE_LAST = 3'(PHASE_COUNT - 1);
  localparam logic [5:0] TRIG_LAST  = 6'(TRIGGER_PERIOD);

  logic [15:0] interval_r;
  logic [15:0] tick_r, tick_nxt;
  logic [23:0] done_r, done_nxt;
  logic [23:0] total_r, total_nxt;
  logic        dir_r, dir_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [3:0]  pins_r, pins_nxt;
  logic        enable_r, enable_nxt;
  logic [5:0]  trig_r, trig_nxt;
  logic        pulse;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic        in_fire;
  logic [16:0] tick_sum;
  logic        fire;
  logic [2:0]  phase_step;

  // hold off transfers while in reset
  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tick_sum = {1'b0, tick_r} + 17'd1;
  assign fire     = tick_sum >= {1'b0, interval_r};

  always_comb begin
    if (dir_r) begin
      phase_step = (phase_r >= PHASE_LAST) ? 3'd0 : phase_r + 3'd1;
    end else begin
      phase_step = (phase_r == 3'd0 || phase_r > PHASE_LAST) ? PHASE_LAST : phase_r - 3'd1;
    end
  end

  always_comb begin
    tick_nxt   = tick_r;
    done_nxt   = done_r;
    total_nxt  = total_r;
    dir_nxt    = dir_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    pins_nxt   = pins_r;
    enable_nxt = enable_r;
    trig_nxt   = trig_r;
    pulse      = 1'b0;
    unique case (in_data.mode)
      MODE_TICK: begin
        tick_nxt = fire ? 16'd0 : tick_sum[15:0];
        if (fire) begin
          if (done_r >= total_r) begin
            // run over: clear the run and engage both brakes
            done_nxt  = '0;
            total_nxt = '0;
            pins_nxt  = pins_r | BRAKE_MASK;
          end else begin
            done_nxt  = done_r + 24'd1;
            phase_nxt = phase_step;
            pos_nxt   = dir_r ? pos_r + 32'd1 : pos_r - 32'd1;
            pins_nxt  = COIL_PATTERN[phase_step];
          end
        end
        if (trig_r >= TRIG_LAST) begin
          trig_nxt = '0;
          pulse    = 1'b1;
        end else begin
          trig_nxt = trig_r + 6'd1;
        end
      end
      MODE_START: begin
        dir_nxt   = in_data.direction;
        total_nxt = in_data.total_steps;
        if (in_data.total_steps != '0 && interval_r != '0) begin
          enable_nxt = 1'b1;
        end
      end
      MODE_STOP: begin
        done_nxt   = '0;
        total_nxt  = '0;
        enable_nxt = 1'b0;
      end
      default: begin
        // unused code: hold all state
      end
    endcase
  end

  always_comb begin
    out_data_nxt.coil_pins     = pins_nxt;
    out_data_nxt.driver_enable = enable_nxt;
    out_data_nxt.range_trigger = pulse;
    out_data_nxt.position      = signed'(pos_nxt);
    out_data_nxt.running       = done_nxt < total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= '0;
      tick_r      <= '0;
      done_r      <= '0;
      total_r     <= '0;
      dir_r       <= 1'b0;
      phase_r     <= '0;
      pos_r       <= '0;
      pins_r      <= '0;
      enable_r    <= 1'b0;
      trig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      if (in_fire) begin
        tick_r   <= tick_nxt;
        done_r   <= done_nxt;
        total_r  <= total_nxt;
        dir_r    <= dir_nxt;
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        pins_r   <= pins_nxt;
        enable_r <= enable_nxt;
        trig_r   <= trig_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on input transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pins_match : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.coil_pins == pins_r && out_data_r.position == signed'(pos_r)))
    else $error("result pins or position differ from sequencer state");

  a_running_has_total : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.running) |-> (total_r != '0))
    else $error("running reported with no steps loaded");

  a_trigger_resets : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!out_data_r.range_trigger || trig_r == '0))
    else $error("trigger pulse without counter restart");

  a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_LAST)
    else $error("phase index beyond pattern length");
`endif

endmodule
